>>> rtl/preemptive_priority_tick_scheduler_macros.svh
// Assertion macros for the preemptive priority tick scheduler.
// Expects clk and rst_n in the scope of use; empty under SYNTHESIS.
`ifndef PREEMPTIVE_PRIORITY_TICK_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_TICK_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pps assertion failed");
// next-cycle implication
`define PPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pps assertion failed");
`else
`define PPS_ASSERT_NOW(label, ante, cons)
`define PPS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/pps_pkg.sv
// Shared types and constants for the preemptive priority tick scheduler.
// No dependencies.
`default_nettype none

package pps_pkg;

    localparam int ENTRIES_DEFAULT = 16;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef logic signed [16:0] prio_t;

    localparam prio_t PRIO_MIN = 17'sh10000;

    typedef struct packed {
        logic [7:0]  number;
        logic [15:0] arrival;
        logic [15:0] remaining;
        prio_t       prio;
    } entry_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  entry_index;
        logic [7:0]  task_number;
        logic [15:0] arrival;
        logic [15:0] run_length;
        logic [14:0] start_priority;
    } cmd_beat_t;

    typedef struct packed {
        logic [31:0] slot_time;
        logic [3:0]  chosen_index;
        logic [7:0]  chosen_number;
        logic        idle;
        logic        finished;
        logic        all_done;
    } slot_beat_t;

endpackage

`default_nettype wire

>>> rtl/pps_cmd_if.sv
// Command channel: valid/ready handshake carrying one cmd_beat_t per beat.
// Depends on pps_pkg.
`default_nettype none

interface pps_cmd_if
    import pps_pkg::*;
();
    logic      valid;
    logic      ready;
    cmd_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/pps_slot_if.sv
// Result channel: valid/ready handshake carrying one slot_beat_t per beat.
// Depends on pps_pkg.
`default_nettype none

interface pps_slot_if
    import pps_pkg::*;
();
    logic       valid;
    logic       ready;
    slot_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/preemptive_priority_tick_scheduler.sv
// Preemptive priority tick scheduler: top level, sequencer and status bits.
// Depends on pps_pkg, pps_cmd_if, pps_slot_if, pps_entry_store and the macros header.
//
//   channel | role   | beat        | when a beat is taken
//   cmd     | sink   | cmd_beat_t  | valid & ready
//   slot    | source | slot_beat_t | valid & ready, one beat per tick command
//
// Load and clear act in the idle state. A tick scans every entry:
// one read of the entry memory per cycle feeds a single priority comparator, then
// the update state writes the chosen entry back and loads the result register.
// cmd is ready in the idle state, also while a result waits; the update cycle
// waits while the result register is still full and slot is not ready.
// Reset clears valid/done bits and time; the entry memory itself has no reset.
`default_nettype none

`include "preemptive_priority_tick_scheduler_macros.svh"

module preemptive_priority_tick_scheduler
    import pps_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input wire logic   clk,
    input wire logic   rst_n,
    pps_cmd_if.sink    cmd,
    pps_slot_if.source slot
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   scan_reg, scan_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    entry_t             best_entry_reg, best_entry_next;
    logic [31:0]        now_reg, now_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] done_reg, done_next;
    logic               out_valid_reg, out_valid_next;
    slot_beat_t         out_data_reg, out_data_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic [IDX_W-1:0]   rd_addr;
    entry_t             rd_data;

    entry_t             upd_entry;
    logic               fin;
    logic [ENTRIES-1:0] fin_vec;
    logic               cand;
    logic               take;
    logic [IDX_W-1:0]   load_idx;

    pps_entry_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        upd_entry = best_entry_reg;
        if (upd_entry.remaining != 16'd0)
        begin
            upd_entry.remaining = upd_entry.remaining - 16'd1;
        end
        if (upd_entry.prio > PRIO_MIN)
        begin
            upd_entry.prio = upd_entry.prio - 17'sd1;
        end
        fin = found_reg && (upd_entry.remaining == 16'd0);
        fin_vec = '0;
        fin_vec[best_idx_reg] = fin;
    end

    assign cand = valid_reg[scan_reg] && !done_reg[scan_reg]
                  && ({16'd0, rd_data.arrival} <= now_reg);
    assign take = cand && (!found_reg || (rd_data.prio > best_entry_reg.prio));
    assign load_idx = IDX_W'(cmd.data.entry_index);

    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_entry_next = best_entry_reg;
        now_next        = now_reg;
        valid_next      = valid_reg;
        done_next       = done_reg;
        out_valid_next  = out_valid_reg && !slot.ready;
        out_data_next   = out_data_reg;
        wr_en           = 1'b0;
        wr_addr         = best_idx_reg;
        wr_data         = upd_entry;
        rd_addr         = scan_reg + IDX_W'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    unique case (cmd.data.operation)
                        OP_LOAD:
                        begin
                            if (32'(cmd.data.entry_index) < 32'(ENTRIES))
                            begin
                                wr_en             = 1'b1;
                                wr_addr           = load_idx;
                                wr_data.number    = cmd.data.task_number;
                                wr_data.arrival   = cmd.data.arrival;
                                wr_data.remaining = cmd.data.run_length;
                                wr_data.prio      = prio_t'({2'b00, cmd.data.start_priority});
                                valid_next[load_idx] = 1'b1;
                                done_next[load_idx]  = (cmd.data.run_length == 16'd0);
                            end
                        end
                        OP_TICK:
                        begin
                            rd_addr    = '0;
                            scan_next  = '0;
                            found_next = 1'b0;
                            state_next = ST_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            valid_next = '0;
                            done_next  = '0;
                            now_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (take)
                begin
                    found_next      = 1'b1;
                    best_idx_next   = scan_reg;
                    best_entry_next = rd_data;
                end
                if (scan_reg == LAST_IDX)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            ST_UPDATE:
            begin
                if (!out_valid_reg || slot.ready)
                begin
                    wr_en                       = found_reg;
                    done_next                   = done_reg | fin_vec;
                    out_valid_next              = 1'b1;
                    out_data_next.slot_time     = now_reg;
                    out_data_next.chosen_index  = found_reg ? 4'(best_idx_reg) : 4'd0;
                    out_data_next.chosen_number = found_reg ? best_entry_reg.number : 8'd0;
                    out_data_next.idle          = !found_reg;
                    out_data_next.finished      = fin;
                    out_data_next.all_done      = ~|(valid_reg & ~(done_reg | fin_vec));
                    if (now_reg != '1)
                    begin
                        now_next = now_reg + 32'd1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            now_reg       <= '0;
            valid_reg     <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            found_reg     <= found_next;
            best_idx_reg  <= best_idx_next;
            now_reg       <= now_next;
            valid_reg     <= valid_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_entry_reg <= best_entry_next;
        out_data_reg   <= out_data_next;
    end

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign slot.valid = out_valid_reg;
    assign slot.data  = out_data_reg;

    `PPS_ASSERT_NOW(a_rose_after_update, $rose(slot.valid), $past(state_reg == ST_UPDATE))
    `PPS_ASSERT_NEXT(a_scan_ends, (state_reg == ST_SCAN) && (scan_reg == LAST_IDX), state_reg == ST_UPDATE)
    `PPS_ASSERT_NOW(a_idle_fields, slot.valid && slot.data.idle, (slot.data.chosen_index == 4'd0) && (slot.data.chosen_number == 8'd0) && !slot.data.finished)

endmodule

`default_nettype wire

>>> rtl/pps_entry_store.sv
// Task entry memory: one write port, one read port with registered data.
// Depends on pps_pkg.
`default_nettype none

module pps_entry_store
    import pps_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT,
    localparam int IDX_W = $clog2(ENTRIES)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire entry_t           wr_data,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_data
);

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
